@@ hw/rtl/nmea_sentence_checksum_framer_macros.svh @@
// ---------------------------------------------------------------------------
// NMEA sentence checksum framer assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKSUM_FRAMER_MACROS_SVH
`define NMEA_SENTENCE_CHECKSUM_FRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSCF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nscf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NSCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nscf assertion failed");

// Next-cycle implication that is also checked across reset.
`define NSCF_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("nscf assertion failed");

`endif

@@ hw/rtl/nscf_pkg.sv @@
// ---------------------------------------------------------------------------
// NMEA sentence checksum framer package
// Widths, character codes, status codes, stage types and the hex decoder.
// ---------------------------------------------------------------------------
package nscf_pkg;

  localparam int MAX_LEN_DEF = 128;
  localparam int ID_CHARS    = 5;
  localparam int ID_W        = 8 * ID_CHARS;
  localparam int TICK_W      = 16;
  localparam int ASC_W       = 3;

  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd50;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [ASC_W-1:0] ASC_HI_DIGIT = 3'd1;
  localparam logic [ASC_W-1:0] ASC_LO_DIGIT = 3'd2;
  localparam logic [ASC_W-1:0] ASC_CHECK    = 3'd4;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERLEN  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [7:0]      computed_checksum;
    logic [ID_W-1:0] sentence_id;
    logic [7:0]      sentence_length;
  } result_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.bad = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

@@ hw/rtl/nmea_sentence_checksum_framer.sv @@
// An accepted transaction waits in the input register; its result then sets the output register.
// Throughput: one transaction per cycle, byte or tick, set by the single framing stage.
// Stalls on the result channel hold the input register and then deassert in_tready.
// Reset: synchronous active-low rst_n clears the valid flags of both stage registers and the
// sentence state, sets the timeout register to 50 ticks and loads the tick counter from it.
// ---------------------------------------------------------------------------
// NMEA sentence checksum framer
// Frames NMEA 0183 sentences, checks the XOR checksum and reports overlong sentences and timeouts.
// ---------------------------------------------------------------------------
module nmea_sentence_checksum_framer
  import nscf_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [TICK_W-1:0] cfg_wr_data,  // byte_timeout_ticks
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,     // rx_byte
  input  logic              in_tuser,     // req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [55:0]       out_tdata,    // computed_checksum, sentence_id, sentence_length
  output logic [1:0]        out_tuser     // status
);

  logic    item_vld;
  item_t   item;
  logic    out_free;
  logic    step;
  logic    res_vld;
  result_t res;

  assign step = item_vld && out_free;

  nscf_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .take      (step),
    .item_vld  (item_vld),
    .item      (item)
  );

  nscf_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (item),
    .res_vld     (res_vld),
    .res         (res)
  );

  nscf_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_vld    (res_vld),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ hw/rtl/nscf_in_stage.sv @@
// ---------------------------------------------------------------------------
// NSCF input stage
// Registers one accepted transaction for the framing logic.
// ---------------------------------------------------------------------------
module nscf_in_stage
  import nscf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  logic  in_tuser,
  input  logic  [7:0] in_tdata,
  input  logic  take,
  output logic  item_vld,
  output item_t item
);

  logic  vld_r;
  item_t item_r;

  assign in_tready = !vld_r || take;
  assign item_vld  = vld_r;
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req_type <= in_tuser;
      item_r.rx_byte  <= in_tdata;
    end
  end

endmodule

@@ hw/rtl/nscf_core.sv @@
// ---------------------------------------------------------------------------
// NSCF framing core
// Sentence state, checksum accumulation, address capture and tick timeout.
// ---------------------------------------------------------------------------
module nscf_core
  import nscf_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [TICK_W-1:0] cfg_wr_data,
  input  logic              step,
  input  item_t             item,
  output logic              res_vld,
  output result_t           res
);

  logic [TICK_W-1:0] timeout_r;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic              in_sent_r, in_sent_nxt;
  logic [7:0]        idx_r, idx_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic              star_r, star_nxt;
  logic [ASC_W-1:0]  asc_r, asc_nxt;
  logic [7:0]        hex_r, hex_nxt;
  logic              bad_r, bad_nxt;
  logic              cr_r, cr_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;

  logic [8:0]        idx_inc;
  logic [7:0]        c;
  hex_t              hd;
  logic              emit;
  logic [1:0]        emit_st;
  logic [7:0]        emit_len;
  logic              clear;

  assign c       = item.rx_byte;
  assign idx_inc = {1'b0, idx_r} + 9'd1;
  assign hd      = hex_decode(c);

  always_comb begin
    ticks_nxt   = ticks_r;
    in_sent_nxt = in_sent_r;
    idx_nxt     = idx_r;
    xor_nxt     = xor_r;
    star_nxt    = star_r;
    asc_nxt     = asc_r;
    hex_nxt     = hex_r;
    bad_nxt     = bad_r;
    cr_nxt      = cr_r;
    id_nxt      = id_r;
    emit        = 1'b0;
    emit_st     = ST_VALID;
    emit_len    = idx_r;
    clear       = 1'b0;

    if (item.req_type == REQ_TICK) begin
      if (ticks_r <= TICK_W'(1)) begin
        emit      = 1'b1;
        emit_st   = ST_TIMEOUT;
        clear     = 1'b1;
        ticks_nxt = timeout_r;
      end else begin
        ticks_nxt = ticks_r - TICK_W'(1);
      end
    end else if (c == CH_DOLLAR) begin
      clear     = 1'b1;
      ticks_nxt = timeout_r;
    end else if (in_sent_r) begin
      ticks_nxt = timeout_r;
      if (idx_inc > 9'(MAX_LEN)) begin
        emit     = 1'b1;
        emit_st  = ST_OVERLEN;
        emit_len = idx_inc[8] ? 8'hFF : idx_inc[7:0];
        clear    = 1'b1;
      end else begin
        idx_nxt  = idx_inc[7:0];
        emit_len = idx_inc[7:0];
        for (int k = 0; k < ID_CHARS; k++) begin
          if (idx_inc == 9'(k + 1)) begin
            id_nxt[ID_W-1-8*k -: 8] = id_r[ID_W-1-8*k -: 8] | c;
          end
        end
        if (!star_r) begin
          if (c == CH_STAR) begin
            star_nxt = 1'b1;
          end else if (c == CH_CR) begin
            cr_nxt = 1'b1;
          end else if (!cr_r) begin
            xor_nxt = xor_r ^ c;
          end
        end else if (asc_r < ASC_CHECK) begin
          asc_nxt = asc_r + ASC_W'(1);
          if (asc_nxt == ASC_HI_DIGIT) begin
            hex_nxt = {hd.val, 4'd0};
            bad_nxt = bad_r | hd.bad;
          end else if (asc_nxt == ASC_LO_DIGIT) begin
            hex_nxt = {hex_r[7:4], hd.val};
            bad_nxt = bad_r | hd.bad;
          end else if (asc_nxt == ASC_CHECK) begin
            emit = 1'b1;
            if (!bad_r && !cr_r && hex_r == xor_r) begin
              emit_st = ST_VALID;
              clear   = 1'b1;
            end else begin
              emit_st = ST_MISMATCH;
            end
          end
        end
      end
    end

    res.status            = emit_st;
    res.computed_checksum = xor_r;
    res.sentence_id       = (emit_st == ST_OVERLEN || emit_st == ST_TIMEOUT) ? id_r : id_nxt;
    res.sentence_length   = emit_len;

    if (clear) begin
      in_sent_nxt = (item.req_type == REQ_BYTE) && (c == CH_DOLLAR);
      idx_nxt     = 8'd0;
      xor_nxt     = 8'd0;
      star_nxt    = 1'b0;
      asc_nxt     = '0;
      hex_nxt     = 8'd0;
      bad_nxt     = 1'b0;
      cr_nxt      = 1'b0;
      id_nxt      = '0;
    end
  end

  assign res_vld = step && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      ticks_r   <= TIMEOUT_RST;
      in_sent_r <= 1'b0;
      idx_r     <= 8'd0;
      xor_r     <= 8'd0;
      star_r    <= 1'b0;
      asc_r     <= '0;
      hex_r     <= 8'd0;
      bad_r     <= 1'b0;
      cr_r      <= 1'b0;
      id_r      <= '0;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
      ticks_r   <= cfg_wr_data;
    end else if (step) begin
      ticks_r   <= ticks_nxt;
      in_sent_r <= in_sent_nxt;
      idx_r     <= idx_nxt;
      xor_r     <= xor_nxt;
      star_r    <= star_nxt;
      asc_r     <= asc_nxt;
      hex_r     <= hex_nxt;
      bad_r     <= bad_nxt;
      cr_r      <= cr_nxt;
      id_r      <= id_nxt;
    end
  end

endmodule

@@ hw/rtl/nscf_out_stage.sv @@
// ---------------------------------------------------------------------------
// NSCF output stage
// Result register that holds a report until the downstream side takes it.
// ---------------------------------------------------------------------------
module nscf_out_stage
  import nscf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_vld,
  input  result_t       res,
  output logic          out_free,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [55:0]   out_tdata,
  output logic [1:0]    out_tuser
);

  logic    vld_r;
  result_t res_r;

  assign out_free   = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = {res_r.sentence_length, res_r.sentence_id, res_r.computed_checksum};
  assign out_tuser  = res_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_vld) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

endmodule

@@ hw/rtl/nscf_checker.sv @@
// ---------------------------------------------------------------------------
// NSCF port checker
// Checks the framer's ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
`include "nmea_sentence_checksum_framer_macros.svh"

module nscf_checker
  import nscf_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser
);

  localparam logic [7:0] OVL_LEN = (MAX_LEN + 1 > 255) ? 8'hFF : 8'(MAX_LEN + 1);

  logic       out_stall;
  logic       out_check;
  logic       out_ovl;
  logic [7:0] out_len;

  assign out_stall = out_tvalid && !out_tready;
  assign out_check = out_tvalid && (out_tuser == ST_VALID || out_tuser == ST_MISMATCH);
  assign out_ovl   = out_tvalid && (out_tuser == ST_OVERLEN);
  assign out_len   = out_tdata[55:48];

  `NSCF_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)
  `NSCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable({out_tuser, out_tdata}))
  `NSCF_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)
  `NSCF_ASSERT_IMPL(a_check_len, clk, rst_n, out_check, out_len >= 8'd5)
  `NSCF_ASSERT_IMPL(a_overlen_len, clk, rst_n, out_ovl, out_len == OVL_LEN)

endmodule

bind nmea_sentence_checksum_framer nscf_checker #(
  .MAX_LEN (MAX_LEN)
) u_nscf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
